/* src/owmr_pkg.sv */
`default_nettype none

package owmr_pkg;

    // memory size and its index width
    localparam int STORE_BYTES = 32;
    localparam int STORE_AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // protocol constants
    localparam logic [7:0] CMD_READ  = 8'hC3;
    localparam int         PAGE_SIZE = 32'h20;
    localparam int         PAGE_AW   = $clog2(PAGE_SIZE);
    localparam logic [7:0] IDLE_BYTE = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h8C;

    // field widths
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int LOAD_IW   = 5;
    localparam int ADDR_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W = 24;
    localparam int IN_USER_W = OP_W;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 1 + STATUS_W;

    // operation of one input beat
    typedef enum logic [OP_W-1:0] {
        OP_BUS_RESET = 2'd0,
        OP_RX_BYTE   = 2'd1,
        OP_READ      = 2'd2,
        OP_LOAD      = 2'd3
    } op_t;

    // status of one result beat
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_UNKNOWN_CMD = 2'd1,
        STATUS_NOT_STREAM  = 2'd2
    } status_t;

    // store write port
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] idx;
        logic [BYTE_W-1:0]   data;
    } store_wr_t;

    // dallas crc-8, reflected, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/owmr_store.sv */
`default_nettype none

module owmr_store (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire owmr_pkg::store_wr_t             wr,
    input  wire logic [owmr_pkg::STORE_AW-1:0]   rd_idx,
    output logic      [owmr_pkg::BYTE_W-1:0]     rd_data
);
    import owmr_pkg::*;

    logic [BYTE_W-1:0] mem_reg [STORE_BYTES];

    // byte store, cleared on reset, written by host loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
                mem_reg[i] <= '0;
        end
        else if (wr.we)
        begin
            mem_reg[wr.idx] <= wr.data;
        end
    end

    // read port
    assign rd_data = mem_reg[rd_idx];

endmodule

`default_nettype wire

/* src/onewire_memory_read_crc8.sv */
`default_nettype none

// channel | dir | tdata (low bit up)                              | tuser
// --------+-----+-------------------------------------------------+--------------------------
// s_      | in  | rx_byte[7:0] load_index[12:8] load_data[20:13]  | op[1:0]
// m_      | out | tx_byte[7:0]                                    | tx_valid[0] status[2:1]
//
// one beat in gives one beat out, in the next cycle; a beat is taken every cycle
// while the result register is empty or being drained.
// the pace is set by the single result register: crc-8 update and store read
// sit in one combinational step between the input port and that register.
// async reset clears phase, address, crc, store and the result valid.
// a stall on m_ holds the result and drops s_tready until it is taken.

module onewire_memory_read_crc8 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [owmr_pkg::IN_DATA_W-1:0]     s_tdata,  // rx_byte, load_index, load_data
    input  wire logic [owmr_pkg::IN_USER_W-1:0]     s_tuser,  // op
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [owmr_pkg::OUT_DATA_W-1:0]    m_tdata,  // tx_byte
    output logic      [owmr_pkg::OUT_USER_W-1:0]    m_tuser   // tx_valid, status
);
    import owmr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ADDR_LO  = 3'd1,
        PH_ADDR_HI  = 3'd2,
        PH_HDR_CRC  = 3'd3,
        PH_STREAM   = 3'd4,
        PH_PAGE_CRC = 3'd5,
        PH_HALTED   = 3'd6
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [7:0]          crc_reg, crc_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   tx_byte_reg, tx_byte_next;
    logic                tx_valid_reg, tx_valid_next;
    status_t             status_reg, status_next;

    logic                accept;
    op_t                 op;
    logic [BYTE_W-1:0]   rx_byte;
    logic [LOAD_IW-1:0]  load_index;
    logic [BYTE_W-1:0]   load_data;
    logic [ADDR_W-1:0]   addr_inc;
    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   stream_byte;
    store_wr_t           store_wr;

    // unpack input beat
    assign op         = op_t'(s_tuser);
    assign rx_byte    = s_tdata[7:0];
    assign load_index = s_tdata[12:8];
    assign load_data  = s_tdata[20:13];

    // result register frees or drains
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // byte store
    assign store_wr.we   = accept && (op == OP_LOAD) && (32'(load_index) < 32'(STORE_BYTES));
    assign store_wr.idx  = STORE_AW'(load_index);
    assign store_wr.data = load_data;

    owmr_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (store_wr),
        .rd_idx  (addr_reg[STORE_AW-1:0]),
        .rd_data (rd_data)
    );

    // streamed byte, idle past the end of the store
    assign stream_byte = (32'(addr_reg) < 32'(STORE_BYTES)) ? rd_data : IDLE_BYTE;
    assign addr_inc    = addr_reg + ADDR_W'(1);

    // next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        addr_next     = addr_reg;
        crc_next      = crc_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        tx_byte_next  = tx_byte_reg;
        tx_valid_next = tx_valid_reg;
        status_next   = status_reg;

        if (accept)
        begin
            m_valid_next  = 1'b1;
            tx_byte_next  = IDLE_BYTE;
            tx_valid_next = 1'b0;
            status_next   = STATUS_OK;

            unique case (op)
                OP_BUS_RESET:
                begin
                    phase_next = PH_IDLE;
                    addr_next  = '0;
                    crc_next   = '0;
                end
                OP_RX_BYTE:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (rx_byte == CMD_READ)
                            begin
                                crc_next   = crc8_byte(8'h00, rx_byte);
                                phase_next = PH_ADDR_LO;
                            end
                            else
                            begin
                                status_next = STATUS_UNKNOWN_CMD;
                                phase_next  = PH_HALTED;
                            end
                        end
                        PH_ADDR_LO:
                        begin
                            crc_next   = crc8_byte(crc_reg, rx_byte);
                            addr_next  = {8'h00, rx_byte};
                            phase_next = PH_ADDR_HI;
                        end
                        PH_ADDR_HI:
                        begin
                            crc_next   = crc8_byte(crc_reg, rx_byte);
                            addr_next  = {rx_byte, addr_reg[7:0]};
                            phase_next = PH_HDR_CRC;
                        end
                        default:
                        begin
                            // ignored once the address is taken, and while halted
                        end
                    endcase
                end
                OP_READ:
                begin
                    unique case (phase_reg)
                        PH_HDR_CRC, PH_PAGE_CRC:
                        begin
                            tx_byte_next  = crc_reg;
                            tx_valid_next = 1'b1;
                            crc_next      = '0;
                            phase_next    = PH_STREAM;
                        end
                        PH_STREAM:
                        begin
                            tx_byte_next  = stream_byte;
                            tx_valid_next = 1'b1;
                            crc_next      = crc8_byte(crc_reg, stream_byte);
                            addr_next     = addr_inc;
                            if (addr_inc[PAGE_AW-1:0] == '0)
                                phase_next = PH_PAGE_CRC;
                        end
                        default:
                        begin
                            status_next = STATUS_NOT_STREAM;
                        end
                    endcase
                end
                OP_LOAD:
                begin
                    // store written through its own port
                end
                default:
                begin
                end
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            addr_reg     <= '0;
            crc_reg      <= '0;
            m_valid_reg  <= 1'b0;
            tx_byte_reg  <= IDLE_BYTE;
            tx_valid_reg <= 1'b0;
            status_reg   <= STATUS_OK;
        end
        else
        begin
            phase_reg    <= phase_next;
            addr_reg     <= addr_next;
            crc_reg      <= crc_next;
            m_valid_reg  <= m_valid_next;
            tx_byte_reg  <= tx_byte_next;
            tx_valid_reg <= tx_valid_next;
            status_reg   <= status_next;
        end
    end

    // output beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tx_byte_reg;
    assign m_tuser  = {status_reg, tx_valid_reg};

endmodule

`default_nettype wire

/* src/owmr_check.sv */
`default_nettype none

module owmr_check (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [owmr_pkg::IN_USER_W-1:0]     s_tuser,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [owmr_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic [owmr_pkg::OUT_USER_W-1:0]    m_tuser
);
    import owmr_pkg::*;

    // a stalled result beat stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped under stall");

    // input side free exactly when the result register can take a beat
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow result register");

    // a byte not flagged valid is the idle byte
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == IDLE_BYTE)
        else $error("idle result carries data");

    // a bus reset beat gives a plain ok result next cycle
    a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_BUS_RESET
        |=> m_tvalid && !m_tuser[0] && m_tuser[2:1] == STATUS_OK)
        else $error("bus reset result wrong");

    // flagged byte only with ok status
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STATUS_OK)
        else $error("data byte with error status");

endmodule

bind onewire_memory_read_crc8 owmr_check u_owmr_check (.*);

`default_nettype wire
